@@ hw/rtl/mtg_pkg.sv @@
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = 10;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FAR_WRAP  = IDX_W'(STATE_WORDS - TWIST_OFFSET);
  localparam logic [IDX_W-1:0] FAR_STEP  = IDX_W'(TWIST_OFFSET);

  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;
  localparam logic [31:0] MATRIX_A   = 32'd2567483615;
  localparam logic [31:0] TEMPER_B   = 32'd2636928640;
  localparam logic [31:0] TEMPER_C   = 32'd4022730752;

  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef struct packed {
    logic        reseed;
    logic [31:0] seed;
  } cmd_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ hw/rtl/mtg_front.sv @@
module mtg_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          operation,
  input  logic [31:0]   seed,
  output logic          cmd_valid,
  output mtg_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import mtg_pkg::*;

  cmd_t       q_mem [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall  = (count == 2'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr].reseed <= (operation == OP_RESEED);
      q_mem[wr_ptr].seed   <= seed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/mtg_core.sv @@
module mtg_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  mtg_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   value,
  output logic          valid_res
);
  import mtg_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SEED  = 3'd1;
  localparam logic [2:0] ST_NEAR  = 3'd2;
  localparam logic [2:0] ST_TWIST = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [31:0]      mem [STATE_WORDS];
  logic [31:0]      rd_a;
  logic [31:0]      rd_b;
  logic [IDX_W-1:0] raddr_a;
  logic [IDX_W-1:0] raddr_b;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;

  logic [2:0]       state;
  logic             seeded;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] far_idx;
  logic [IDX_W-1:0] cnt;
  logic [31:0]      p;
  logic [31:0]      p_next;
  logic [31:0]      mix;
  logic [31:0]      ymix;
  logic [31:0]      twisted;
  logic [31:0]      res_value;
  logic             res_ok;
  logic             slot_free;

  assign idx_next  = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign far_idx   = (idx < FAR_WRAP) ? idx + FAR_STEP : idx - FAR_WRAP;
  assign mix       = p ^ (p >> 30);
  assign p_next    = INIT_MULT * mix + 32'(cnt) + 32'd1;
  assign twisted   = rd_a ^ (ymix >> 1) ^ (ymix[0] ? MATRIX_A : 32'd0);
  assign slot_free = !out_valid || !out_stall;
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;

  always_comb begin
    raddr_a = idx;
    raddr_b = idx_next;
    if (state == ST_NEAR) raddr_a = far_idx;
    we    = 1'b0;
    waddr = idx;
    wdata = twisted;
    unique case (state)
      ST_SEED: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = p;
      end
      ST_TWIST: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (state == ST_NEAR) ymix <= (rd_a & UPPER_MASK) | (rd_b & LOWER_MASK);
    if (state == ST_SEED) p <= p_next;
    if (cmd_pop && cmd.reseed) p <= cmd.seed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seeded    <= 1'b0;
      idx       <= '0;
      cnt       <= '0;
      res_value <= '0;
      res_ok    <= 1'b0;
      out_valid <= 1'b0;
      value     <= '0;
      valid_res <= 1'b0;
    end else begin
      if (state == ST_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.reseed) begin
              cnt   <= '0;
              state <= ST_SEED;
            end else if (!seeded) begin
              res_value <= '0;
              res_ok    <= 1'b0;
              state     <= ST_EMIT;
            end else begin
              state <= ST_NEAR;
            end
          end
        end
        ST_SEED: begin
          if (cnt == LAST_IDX) begin
            seeded    <= 1'b1;
            idx       <= '0;
            res_value <= '0;
            res_ok    <= 1'b0;
            state     <= ST_EMIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_NEAR: state <= ST_TWIST;
        ST_TWIST: begin
          res_value <= temper(twisted);
          res_ok    <= 1'b1;
          idx       <= idx_next;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            value     <= res_value;
            valid_res <= res_ok;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= LAST_IDX)
    else $error("read index out of range");

  a_draw_seeded: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> seeded)
    else $error("real draw from unseeded generator");

  a_twist_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_TWIST |-> $past(state) == ST_NEAR)
    else $error("twist step without operand fetch");

  a_seed_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEED |-> cnt <= LAST_IDX)
    else $error("seed counter out of range");

endmodule

@@ hw/rtl/mersenne_twister_generator.sv @@
// Draw: seeded runs fetch, twist, emit, then the output register; unseeded skips to emit.
// Reseed: one table word written per cycle through the init multiplier.
// The engine takes a new command only in idle, once the fetch/twist/write sequence is done.
// A 2-beat input queue keeps accepting while the engine or the output is busy, until it is full.
// Reset empties the queue and output and clears the seeded flag; the read index returns to
// word 0. Table contents are undefined until the first reseed.
module mersenne_twister_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  output logic        valid_res
);
  import mtg_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  mtg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .seed      (seed),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mtg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .valid_res (valid_res)
  );

endmodule

@@ tb/mersenne_twister_generator_test.sv @@
module mersenne_twister_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mtg_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [31:0] value;
    logic        valid_res;
  } mt_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_DRAW;
  logic [31:0] seed = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] value;
  logic        valid_res;

  // predictor state
  logic [31:0] mt_words [STATE_WORDS];
  int          mt_pos = STATE_WORDS;
  bit          mt_seeded = 1'b0;

  mt_result_t  words_due [$];
  int          cycle_count = 0;
  int          fail_count = 0;
  int          results_checked = 0;
  int          reseeds_sent = 0;
  int          draws_sent = 0;
  int          burst_left = 0;
  int          gap_max = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  stall_kind_t stall_mode = STALL_NONE;

  mersenne_twister_generator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .seed      (seed),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .valid_res (valid_res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, words_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void mt_fill(logic [31:0] s);
    logic [31:0] p;
    int          k;
    mt_words[0] = s;
    for (k = 1; k < STATE_WORDS; k++) begin
      p = mt_words[k-1];
      mt_words[k] = INIT_MULT * (p ^ (p >> 30)) + 32'(k);
    end
  endfunction

  function automatic void mt_twist();
    logic [31:0] y;
    logic [31:0] w;
    int          k;
    for (k = 0; k < STATE_WORDS; k++) begin
      y = (mt_words[k] & UPPER_MASK) | (mt_words[(k + 1) % STATE_WORDS] & LOWER_MASK);
      w = mt_words[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
      if (y[0])
        w = w ^ MATRIX_A;
      mt_words[k] = w;
    end
  endfunction

  function automatic mt_result_t mt_step(logic op, logic [31:0] s);
    mt_result_t  r;
    logic [31:0] t;
    r.value = '0;
    r.valid_res = 1'b0;
    if (op == OP_RESEED) begin
      mt_fill(s);
      mt_pos = STATE_WORDS;
      mt_seeded = 1'b1;
    end else if (mt_seeded) begin
      if (mt_pos >= STATE_WORDS) begin
        mt_twist();
        mt_pos = 0;
      end
      t = mt_words[mt_pos];
      mt_pos++;
      t = t ^ (t >> 11);
      t = t ^ ((t << 7) & TEMPER_B);
      t = t ^ ((t << 15) & TEMPER_C);
      t = t ^ (t >> 18);
      r.value = t;
      r.valid_res = 1'b1;
    end
    return r;
  endfunction

  function automatic void note_failure(string what, logic [31:0] want, logic [31:0] got);
    if (fail_count < 10)
      $display("[%0d] %s: expected %h, got %h", cycle_count, what, want, got);
    fail_count++;
  endfunction

  // receiver: stall pattern plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ((cycle_count % 9) >= 6);
      endcase
    end
  end

  always @(posedge clk) begin
    mt_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (words_due.size() == 0) begin
        note_failure("unexpected result beat", '0, value);
      end else begin
        want = words_due.pop_front();
        results_checked++;
        if (value !== want.value)
          note_failure("value", want.value, value);
        if (valid_res !== want.valid_res)
          note_failure("valid_res", 32'(want.valid_res), 32'(valid_res));
      end
    end
  end

  task automatic send_beat(input logic op, input logic [31:0] s);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid  <= 1'b1;
    operation <= op;
    seed      <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_due.push_back(mt_step(op, s));
    if (op == OP_RESEED)
      reseeds_sent++;
    else
      draws_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_unseeded_draws();
    stall_mode = STALL_NONE;
    gap_max = 0;
    send_beat(OP_DRAW, 32'h0000_0000);
    send_beat(OP_DRAW, 32'hffff_ffff);
    send_beat(OP_DRAW, $urandom());
  endtask

  task automatic test_seed_extremes();
    stall_mode = STALL_LIGHT;
    gap_max = 3;
    send_beat(OP_RESEED, 32'd5489);
    repeat (3) send_beat(OP_DRAW, $urandom());
    send_beat(OP_RESEED, 32'h0000_0000);
    repeat (2) send_beat(OP_DRAW, 32'hffff_ffff);
    send_beat(OP_RESEED, 32'hffff_ffff);
    repeat (2) send_beat(OP_DRAW, 32'h0000_0000);
  endtask

  task automatic test_repeated_reseed();
    stall_mode = STALL_PATTERN;
    gap_max = 0;
    send_beat(OP_RESEED, 32'h0000_0001);
    send_beat(OP_RESEED, 32'h8000_0000);
    repeat (2) send_beat(OP_DRAW, $urandom());
  endtask

  // run past the end of the table so the second twist is exercised
  task automatic test_twist_wrap();
    stall_mode = STALL_LIGHT;
    gap_max = 4;
    send_beat(OP_RESEED, $urandom());
    repeat (STATE_WORDS + 6) send_beat(OP_DRAW, $urandom());
  endtask

  task automatic test_output_hold();
    wait_drained();
    stall_mode = STALL_NONE;
    gap_max = 0;
    hold_req = 200;
    repeat (12) send_beat(OP_DRAW, $urandom());
    wait_drained();
  endtask

  task automatic test_random_streams(input int beats);
    int left;
    int run_len;
    left = beats;
    while (left > 0) begin
      stall_mode = stall_kind_t'($urandom_range(0, 3));
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0)
        hold_req = $urandom_range(30, 120);
      send_beat(OP_RESEED, $urandom());
      left--;
      run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(STATE_WORDS + 1, 700)
                                            : $urandom_range(0, 30);
      if (run_len > left)
        run_len = left;
      repeat (run_len) begin
        send_beat(OP_DRAW, $urandom());
        left--;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_unseeded_draws();
    test_seed_extremes();
    test_repeated_reseed();
    test_twist_wrap();
    test_output_hold();
    test_random_streams(1100);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d reseeds and %0d draws, %0d results checked in %0d cycles",
             reseeds_sent, draws_sent, results_checked, cycle_count);
    $display("Covered unseeded draws, seed extremes, back-to-back reseeds, table wrap");
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ mersenne_twister_generator.f @@
hw/rtl/mtg_pkg.sv
hw/rtl/mtg_front.sv
hw/rtl/mtg_core.sv
hw/rtl/mersenne_twister_generator.sv
tb/mersenne_twister_generator_test.sv
